/* src/atpr_pkg.sv */
// atpr_pkg: shared widths, constants, the transaction type between front and back
// and the arctangent table and output rounding used by the tilt angle unit
// no dependencies
package atpr_pkg;

   localparam int FIELD_W    = 16;
   localparam int PITCH_W    = 15;
   localparam int ROLL_W     = 16;
   localparam int SAMPLE_W   = 32;
   localparam int VEC_W      = 36;
   localparam int ANG_W      = 35;
   localparam int STEP_IDX_W = 5;
   localparam int TABLE_LEN  = 24;

   localparam int ROUND_SHIFT = 17;
   localparam int RND_W       = ANG_W - ROUND_SHIFT;

   localparam int GAIN_W     = 30;
   localparam int MAG_W      = 33;
   localparam int MAG_LO_W   = 17;
   localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
   localparam int PROD_HI_W  = MAG_HI_W + GAIN_W;
   localparam int PROD_LO_W  = MAG_LO_W + GAIN_W;
   localparam int SUM_W      = 64;

   localparam int QUEUE_DEPTH = 4;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int SAMPLE_BITS_DEF  = 16;

   localparam logic signed [ANG_W-1:0] PI_Q30     = 35'sd3373259426;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 35'sd65536;
   localparam logic [GAIN_W-1:0]       INV_GAIN_Q30 = 30'd652032874;
   localparam logic [SUM_W-1:0]        GAIN_ROUND   = 64'd536870912;

   localparam logic signed [RND_W-1:0] PITCH_LIMIT = 18'sd12868;
   localparam logic signed [RND_W-1:0] ROLL_LIMIT  = 18'sd25736;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic signed [VEC_W-1:0]    a;
      logic signed [VEC_W-1:0]    b;
      logic signed [ANG_W-1:0]    ang;
      logic                       roll_zero;
   } front_item_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STEP_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:    val = 35'sd843314857;
         5'd1:    val = 35'sd497837829;
         5'd2:    val = 35'sd263043837;
         5'd3:    val = 35'sd133525159;
         5'd4:    val = 35'sd67021687;
         5'd5:    val = 35'sd33543516;
         5'd6:    val = 35'sd16775851;
         5'd7:    val = 35'sd8388437;
         5'd8:    val = 35'sd4194283;
         5'd9:    val = 35'sd2097149;
         5'd10:   val = 35'sd1048576;
         5'd11:   val = 35'sd524288;
         5'd12:   val = 35'sd262144;
         5'd13:   val = 35'sd131072;
         5'd14:   val = 35'sd65536;
         5'd15:   val = 35'sd32768;
         5'd16:   val = 35'sd16384;
         5'd17:   val = 35'sd8192;
         5'd18:   val = 35'sd4096;
         5'd19:   val = 35'sd2048;
         5'd20:   val = 35'sd1024;
         5'd21:   val = 35'sd512;
         5'd22:   val = 35'sd256;
         5'd23:   val = 35'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

   // q30 radians to q13, half rounds up, then clamp to +/- limit
   function automatic logic signed [RND_W-1:0] round_sat(input logic signed [ANG_W-1:0] ang,
                                                         input logic signed [RND_W-1:0] limit);
      logic signed [ANG_W-1:0] sum;
      logic signed [RND_W-1:0] q;
      sum = ang + ROUND_HALF;
      q   = $signed(sum[ANG_W-1:ROUND_SHIFT]);
      if (q > limit) begin
         q = limit;
      end else if (q < -limit) begin
         q = -limit;
      end
      return q;
   endfunction

endpackage

/* src/atpr_front.sv */
// atpr_front: accepts a sample, scales it and folds the roll vector into the right
// half plane, flagging the zero vector; holds one transaction for the queue
// depends on atpr_pkg
module atpr_front #(
   parameter int SAMPLE_BITS = atpr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_x,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_y,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_z,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output atpr_pkg::front_item_type             out_item
);
   import atpr_pkg::*;

   localparam int LEAD = SAMPLE_W - SAMPLE_BITS;

   function automatic logic signed [SAMPLE_W-1:0] load_sample(input logic [FIELD_W-1:0] raw);
      logic [SAMPLE_W-1:0] wide;
      logic [SAMPLE_W-1:0] aligned;
      wide    = {{(SAMPLE_W-FIELD_W){1'b0}}, raw};
      aligned = wide << LEAD;
      return $signed(aligned) >>> 1;
   endfunction

   logic            valid_ff;
   logic            valid_in;
   logic            load;
   front_item_type  item_ff;
   front_item_type  item_in;

   logic signed [SAMPLE_W-1:0] sx, sy, sz;
   logic signed [VEC_W-1:0]    za, nb;

   assign load      = !valid_ff || out_ready;
   assign req_ready = load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_comb begin
      sx = load_sample($unsigned(req_accel_x));
      sy = load_sample($unsigned(req_accel_y));
      sz = load_sample($unsigned(req_accel_z));
      za = VEC_W'(sz);
      nb = -VEC_W'(sy);
      item_in.x         = sx;
      item_in.roll_zero = (sz == '0) && (sy == '0);
      if (za < 0) begin
         item_in.ang = (nb >= 0) ? PI_Q30 : -PI_Q30;
         item_in.a   = -za;
         item_in.b   = -nb;
      end else begin
         item_in.ang = '0;
         item_in.a   = za;
         item_in.b   = nb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/atpr_queue.sv */
// atpr_queue: short register queue between front and back
// no package dependencies
module atpr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   ap_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill beyond depth");

   ap_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill did not follow a lone push");

   ap_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("queue pointers apart while empty");

endmodule

/* src/atpr_vector_pipe.sv */
// atpr_vector_pipe: unrolled cordic vectoring, one registered step per stage,
// with a sideband carried alongside; depends on atpr_pkg
module atpr_vector_pipe #(
   parameter int STEPS  = atpr_pkg::CORDIC_STEPS_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [atpr_pkg::VEC_W-1:0]  in_a,
   input  logic signed [atpr_pkg::VEC_W-1:0]  in_b,
   input  logic signed [atpr_pkg::ANG_W-1:0]  in_ang,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic signed [atpr_pkg::VEC_W-1:0]  out_a,
   output logic signed [atpr_pkg::ANG_W-1:0]  out_ang,
   output logic [SIDE_W-1:0]                  out_side
);
   import atpr_pkg::*;

   logic                    valid_ff [STEPS];
   logic signed [VEC_W-1:0] a_ff     [STEPS];
   logic signed [VEC_W-1:0] b_ff     [STEPS];
   logic signed [ANG_W-1:0] ang_ff   [STEPS];
   logic [SIDE_W-1:0]       side_ff  [STEPS];

   genvar k;
   generate
      for (k = 0; k < STEPS; k++) begin : g_step
         logic                    src_valid;
         logic signed [VEC_W-1:0] src_a, src_b, a_in, b_in;
         logic signed [ANG_W-1:0] src_ang, ang_in;
         logic [SIDE_W-1:0]       src_side;

         if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_a     = in_a;
            assign src_b     = in_b;
            assign src_ang   = in_ang;
            assign src_side  = in_side;
         end else begin : g_next
            assign src_valid = valid_ff[k-1];
            assign src_a     = a_ff[k-1];
            assign src_b     = b_ff[k-1];
            assign src_ang   = ang_ff[k-1];
            assign src_side  = side_ff[k-1];
         end

         always_comb begin
            if (!src_b[VEC_W-1]) begin
               a_in   = src_a + (src_b >>> k);
               b_in   = src_b - (src_a >>> k);
               ang_in = src_ang + atan_q30(STEP_IDX_W'(k));
            end else begin
               a_in   = src_a - (src_b >>> k);
               b_in   = src_b + (src_a >>> k);
               ang_in = src_ang - atan_q30(STEP_IDX_W'(k));
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (advance) begin
               valid_ff[k] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               a_ff[k]    <= a_in;
               b_ff[k]    <= b_in;
               ang_ff[k]  <= ang_in;
               side_ff[k] <= src_side;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_a     = a_ff[STEPS-1];
   assign out_ang   = ang_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

/* src/atpr_back.sv */
// atpr_back: roll vectoring pass, gain removal, pitch vectoring pass and the
// result register; depends on atpr_pkg and atpr_vector_pipe
module atpr_back #(
   parameter int CORDIC_STEPS = atpr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  atpr_pkg::front_item_type             in_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [atpr_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [atpr_pkg::ROLL_W-1:0]   rsp_roll_angle
);
   import atpr_pkg::*;

   localparam int RSIDE_W = SAMPLE_W + 1;
   localparam int PSIDE_W = ROLL_W + 1;

   logic advance;

   // roll pass
   logic                    roll_valid;
   logic signed [VEC_W-1:0] roll_mag;
   logic signed [ANG_W-1:0] roll_ang;
   logic [RSIDE_W-1:0]      roll_side;

   // gain removal
   logic                       m1_valid_ff, m1_valid_in;
   logic [PROD_HI_W-1:0]       p_hi_ff, p_hi_in;
   logic [PROD_LO_W-1:0]       p_lo_ff, p_lo_in;
   logic signed [SAMPLE_W-1:0] m1_x_ff;
   logic signed [ROLL_W-1:0]   m1_roll_ff, m1_roll_in;
   logic [MAG_W-1:0]           mag;

   logic                       m2_valid_ff;
   logic [MAG_W-1:0]           r_ff, r_in;
   logic signed [SAMPLE_W-1:0] m2_x_ff;
   logic signed [ROLL_W-1:0]   m2_roll_ff;
   logic [SUM_W-1:0]           gain_sum;

   // pitch pass
   logic                    pitch_zero;
   logic signed [VEC_W-1:0] pitch_a, pitch_b;
   logic                    pitch_valid;
   logic signed [ANG_W-1:0] pitch_ang;
   logic [PSIDE_W-1:0]      pitch_side;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [PITCH_W-1:0]  rsp_pitch_ff, rsp_pitch_in;
   logic signed [ROLL_W-1:0]   rsp_roll_ff;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign in_ready = advance;

   atpr_vector_pipe #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (RSIDE_W)
   ) u_roll_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_a      (in_item.a),
      .in_b      (in_item.b),
      .in_ang    (in_item.ang),
      .in_side   ({in_item.x, in_item.roll_zero}),
      .out_valid (roll_valid),
      .out_a     (roll_mag),
      .out_ang   (roll_ang),
      .out_side  (roll_side)
   );

   always_comb begin
      mag         = roll_mag[MAG_W-1:0];
      m1_valid_in = roll_valid;
      p_hi_in     = PROD_HI_W'(mag[MAG_W-1:MAG_LO_W]) * PROD_HI_W'(INV_GAIN_Q30);
      p_lo_in     = PROD_LO_W'(mag[MAG_LO_W-1:0]) * PROD_LO_W'(INV_GAIN_Q30);
      m1_roll_in  = roll_side[0] ? '0 : ROLL_W'(round_sat(roll_ang, ROLL_LIMIT));
   end

   assign gain_sum = (SUM_W'(p_hi_ff) << MAG_LO_W) + SUM_W'(p_lo_ff) + GAIN_ROUND;
   assign r_in     = gain_sum[GAIN_W +: MAG_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= m1_valid_in;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_hi_ff    <= p_hi_in;
         p_lo_ff    <= p_lo_in;
         m1_x_ff    <= roll_side[RSIDE_W-1:1];
         m1_roll_ff <= m1_roll_in;
         r_ff       <= r_in;
         m2_x_ff    <= m1_x_ff;
         m2_roll_ff <= m1_roll_ff;
      end
   end

   assign pitch_zero = (r_ff == '0) && (m2_x_ff == '0);
   assign pitch_a    = $signed({{(VEC_W-MAG_W){1'b0}}, r_ff});
   assign pitch_b    = VEC_W'(m2_x_ff);

   atpr_vector_pipe #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (PSIDE_W)
   ) u_pitch_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m2_valid_ff),
      .in_a      (pitch_a),
      .in_b      (pitch_b),
      .in_ang    ('0),
      .in_side   ({pitch_zero, m2_roll_ff}),
      .out_valid (pitch_valid),
      .out_a     (),
      .out_ang   (pitch_ang),
      .out_side  (pitch_side)
   );

   assign rsp_valid_in = advance ? pitch_valid : rsp_valid_ff;
   assign rsp_pitch_in = pitch_side[ROLL_W] ? '0 : PITCH_W'(round_sat(pitch_ang, PITCH_LIMIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pitch_ff <= rsp_pitch_in;
         rsp_roll_ff  <= pitch_side[ROLL_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_roll_angle  = rsp_roll_ff;

   ap_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_roll_ff <= ROLL_LIMIT && rsp_roll_ff >= -ROLL_LIMIT))
      else $error("roll outside clamp range");

   ap_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pitch_ff <= PITCH_LIMIT && rsp_pitch_ff >= -PITCH_LIMIT))
      else $error("pitch outside clamp range");

   ap_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pitch_valid))
      else $error("result appeared without a finished pitch pass");

endmodule

/* src/accel_tilt_pitch_roll_unit.sv */
// Accelerometer tilt unit: one three-axis sample in, pitch in Q2.13 and roll in Q3.13 radians out.
// req_* channel: accel_x/y/z signed counts, valid/ready; a transaction is taken when both
// are high. rsp_* channel: pitch_angle (15 bits) and roll_angle (16 bits), valid/ready.
// pitch = atan2(x, sqrt(y*y+z*z)), roll = atan2(-y, z), atan2(0,0) = 0, both clamped.
// Between request and response lie one front register, one queue slot, the roll cordic
// stages, two gain-removal stages, the pitch cordic stages and the result register.
// Throughput is one transaction per cycle while the back pipeline is not held, set by the
// unrolled cordic pipelines which take a new vector every cycle.
// While a result waits with rsp_ready low the whole back pipeline holds; the four-entry queue
// and the front register keep absorbing transactions until full, and req_ready then drops.
// Reset (synchronous, active high) empties the queue and clears all valid flags; the data
// registers are not reset, and the block is ready in the cycle after reset falls.
// depends on atpr_pkg, atpr_front, atpr_queue, atpr_back
module accel_tilt_pitch_roll_unit #(
   parameter int CORDIC_STEPS = atpr_pkg::CORDIC_STEPS_DEF,
   parameter int SAMPLE_BITS  = atpr_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_x,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_y,
   input  logic signed [atpr_pkg::FIELD_W-1:0]  req_accel_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [atpr_pkg::PITCH_W-1:0]  rsp_pitch_angle,
   output logic signed [atpr_pkg::ROLL_W-1:0]   rsp_roll_angle
);
   import atpr_pkg::*;

   localparam int ITEM_W = $bits(front_item_type);

   logic           front_valid, front_ready;
   front_item_type front_item;
   logic           q_valid, q_ready;
   logic [ITEM_W-1:0] q_data;
   front_item_type q_item;

   atpr_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_item    (front_item)
   );

   atpr_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_item = front_item_type'(q_data);

   atpr_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_item         (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pitch_angle (rsp_pitch_angle),
      .rsp_roll_angle  (rsp_roll_angle)
   );

endmodule
